// File: rtl/aes_key_slot_scrambler_macros.svh
// assertion helpers for the key slot scrambler
`ifndef AES_KEY_SLOT_SCRAMBLER_MACROS_SVH
`define AES_KEY_SLOT_SCRAMBLER_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define AKS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aks: same-cycle check failed");

// next-cycle implication, sampled on clk, off during rst
`define AKS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aks: next-cycle check failed");

`endif

// File: rtl/aks_pkg.sv
package aks_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int COMMON_SLOT = 61;
  localparam int SLOT_CAP    = 64;
  localparam int NUM_COMMON  = 6;

  localparam int SLOT_W = 6;
  localparam int ADDR_W = SLOT_W + 1;
  localparam int WORD_W = 64;
  localparam int KEY_W  = 2 * WORD_W;

  // rotation applied to the scrambled sum
  localparam int ROT_NORMAL = 87;

  localparam logic [WORD_W-1:0] SCRAMBLE_HI = 64'h1FF9_E9AA_C5FE_0408;
  localparam logic [WORD_W-1:0] SCRAMBLE_LO = 64'h0245_91DC_5D52_768A;

  localparam logic COMMON_SLOT_BAD = (COMMON_SLOT >= NUM_SLOTS);

  typedef enum logic [2:0] {
    CMD_WR_X   = 3'd0,
    CMD_WR_Y   = 3'd1,
    CMD_WR_N   = 3'd2,
    CMD_RD_N   = 3'd3,
    CMD_RD_X   = 3'd4,
    CMD_COMMON = 3'd5,
    CMD_CLEAR  = 3'd6
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LOW,
    ST_HIGH,
    ST_NHI,
    ST_NLO,
    ST_DONE
  } state_t;

  // built-in key Y values, big-endian
  function automatic logic [KEY_W-1:0] common_key_y(input logic [2:0] idx);
    logic [KEY_W-1:0] k;
    unique case (idx)
      3'd0:    k = 128'hD07B337F9CA43859_32A2E25723232EB9;
      3'd1:    k = 128'h0C767230F0998F1C_46828202FAACBE4C;
      3'd2:    k = 128'hC475CB3AB8C788BB_575E12A10907B8A4;
      3'd3:    k = 128'hE486EEE3D0C09C90_2F6686D4C06F649F;
      3'd4:    k = 128'hED31BA9C04B06750_6C4497A35B7804FC;
      3'd5:    k = 128'h5E66998AB4E89316_06850FD7A16DD755;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/aes_key_slot_scrambler.sv
// key slot table with key X / key Y scrambler. each command arrives as one
// transfer on the s_ side and produces exactly one result transfer on the
// m_ side. a slot keeps key X, key Y and a normal key, each with a valid
// bit; writing X or Y (or loading a built-in Y into the common slot)
// rebuilds the normal key as rol87((rol2(X) ^ Y) + C) when both halves are
// valid, otherwise the normal key goes invalid. keys live in three 128x64
// word memories (high word at even address), written one word per cycle.
// the 128-bit add runs on one shared 64-bit adder, low word then high word
// with a carry flop. a key X/Y or common-key write that rebuilds the
// normal key steps through load, low, high, nhi and nlo, other writes
// through load and low, reads, clear, faults and the unused code through
// load alone; the single memory write port and the two-pass adder set
// these steps. one command is in flight at a time, but a new command is
// taken while the last result still waits in the output register. clear
// drops all valid bits at once; stored words are kept but read back as zero.
module aes_key_slot_scrambler (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[2:0], slot[8:3], common_index[11:9], key_high[75:12],
  // key_low[139:76], zero pad[143:140]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // read_high[63:0], read_low[127:64], present[128], fault[129],
  // zero pad[135:130]
  output logic [135:0] m_tdata
);

  import aks_pkg::*;

  // fsm
  state_t state, state_next;

  // latched command
  cmd_t              cmd;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] ws;         // slot actually addressed
  logic [2:0]        cidx;
  logic [WORD_W-1:0] key_hi;
  logic [WORD_W-1:0] key_lo;

  logic regen;                   // rebuild normal key after the write
  logic pres;
  logic fault_q;
  logic fault_c;

  // valid bits, one per slot
  logic [SLOT_CAP-1:0] valid_x;
  logic [SLOT_CAP-1:0] valid_y;
  logic [SLOT_CAP-1:0] valid_normal;

  // word memories, high word at even address
  logic [WORD_W-1:0] mem_x [2*SLOT_CAP];
  logic [WORD_W-1:0] mem_y [2*SLOT_CAP];
  logic [WORD_W-1:0] mem_n [2*SLOT_CAP];

  logic [WORD_W-1:0] rd_x_hi, rd_x_lo;
  logic [WORD_W-1:0] rd_y_hi, rd_y_lo;
  logic [WORD_W-1:0] rd_n_hi, rd_n_lo;

  logic              we_x, we_y, we_n;
  logic [ADDR_W-1:0] wr_addr;
  logic [WORD_W-1:0] wr_data;

  // scrambler datapath
  logic [KEY_W-1:0]  x_key, y_key, x_rot, mix, sum, norm;
  logic [WORD_W-1:0] add_a, add_b;
  logic              add_cin;
  logic [WORD_W:0]   add_out;
  logic [WORD_W-1:0] sum_hi, sum_lo;
  logic              carry;

  logic [KEY_W-1:0]  rd_key;

  assign s_tready = (state == ST_IDLE);

  // ---------------------------------------------------------------------
  // command capture
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd    <= cmd_t'(s_tdata[2:0]);
      slot   <= s_tdata[8:3];
      cidx   <= s_tdata[11:9];
      key_hi <= s_tdata[75:12];
      key_lo <= s_tdata[139:76];
      // common-key load always targets the fixed ticket slot
      if (cmd_t'(s_tdata[2:0]) == CMD_COMMON) begin
        ws <= SLOT_W'(COMMON_SLOT);
      end else begin
        ws <= s_tdata[8:3];
      end
    end
  end

  // out-of-range slot on slot commands, bad table index on common load
  always_comb begin
    fault_c = 1'b0;
    unique case (cmd)
      CMD_WR_X, CMD_WR_Y, CMD_WR_N, CMD_RD_N, CMD_RD_X: begin
        fault_c = ({1'b0, slot} >= ADDR_W'(NUM_SLOTS));
      end
      CMD_COMMON: begin
        fault_c = (cidx >= 3'(NUM_COMMON)) || COMMON_SLOT_BAD;
      end
      default: begin
        fault_c = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (fault_c) begin
          state_next = ST_DONE;
        end else begin
          unique case (cmd)
            CMD_WR_X, CMD_WR_Y, CMD_WR_N, CMD_COMMON: state_next = ST_LOW;
            default:                                  state_next = ST_DONE;
          endcase
        end
      end
      ST_LOW: begin
        state_next = regen ? ST_HIGH : ST_DONE;
      end
      ST_HIGH: state_next = ST_NHI;
      ST_NHI:  state_next = ST_NLO;
      ST_NLO:  state_next = ST_DONE;
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // memory write controls and adder operand steering
  always_comb begin
    we_x    = 1'b0;
    we_y    = 1'b0;
    we_n    = 1'b0;
    wr_addr = {ws, 1'b0};
    wr_data = key_hi;
    add_a   = mix[WORD_W-1:0];
    add_b   = SCRAMBLE_LO;
    add_cin = 1'b0;
    unique case (state)
      ST_LOAD, ST_LOW: begin
        wr_addr = {ws, (state == ST_LOW)};
        if (cmd == CMD_COMMON) begin
          wr_data = (state == ST_LOW) ? y_key[WORD_W-1:0] : y_key[KEY_W-1:WORD_W];
        end else begin
          wr_data = (state == ST_LOW) ? key_lo : key_hi;
        end
        if (!fault_c) begin
          we_x = (cmd == CMD_WR_X);
          we_y = (cmd == CMD_WR_Y) || (cmd == CMD_COMMON);
          we_n = (cmd == CMD_WR_N);
        end
      end
      ST_HIGH: begin
        add_a   = mix[KEY_W-1:WORD_W];
        add_b   = SCRAMBLE_HI;
        add_cin = carry;
      end
      ST_NHI: begin
        we_n    = 1'b1;
        wr_addr = {ws, 1'b0};
        wr_data = norm[KEY_W-1:WORD_W];
      end
      ST_NLO: begin
        we_n    = 1'b1;
        wr_addr = {ws, 1'b1};
        wr_data = norm[WORD_W-1:0];
      end
      default: begin
        we_x = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------
  // valid bits and per-command flags
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_x      <= '0;
      valid_y      <= '0;
      valid_normal <= '0;
    end else if (state == ST_LOAD && !fault_c) begin
      unique case (cmd)
        CMD_WR_X: begin
          valid_x[ws]      <= 1'b1;
          valid_normal[ws] <= valid_y[ws];
        end
        CMD_WR_Y, CMD_COMMON: begin
          valid_y[ws]      <= 1'b1;
          valid_normal[ws] <= valid_x[ws];
        end
        CMD_WR_N: begin
          valid_normal[ws] <= 1'b1;
        end
        CMD_CLEAR: begin
          valid_x      <= '0;
          valid_y      <= '0;
          valid_normal <= '0;
        end
        default: begin
          valid_x <= valid_x;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      fault_q <= fault_c;
      regen   <= !fault_c && (((cmd == CMD_WR_X) && valid_y[ws]) ||
                 (((cmd == CMD_WR_Y) || (cmd == CMD_COMMON)) && valid_x[ws]));
      pres    <= !fault_c && (((cmd == CMD_RD_N) && valid_normal[ws]) ||
                 ((cmd == CMD_RD_X) && valid_x[ws]));
    end
  end

  // ---------------------------------------------------------------------
  // key memories: one write port, both words of a slot read together
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (we_x) begin
      mem_x[wr_addr] <= wr_data;
    end
    if (state == ST_LOAD) begin
      rd_x_hi <= mem_x[{ws, 1'b0}];
      rd_x_lo <= mem_x[{ws, 1'b1}];
    end
  end

  always_ff @(posedge clk) begin
    if (we_y) begin
      mem_y[wr_addr] <= wr_data;
    end
    if (state == ST_LOAD) begin
      rd_y_hi <= mem_y[{ws, 1'b0}];
      rd_y_lo <= mem_y[{ws, 1'b1}];
    end
  end

  always_ff @(posedge clk) begin
    if (we_n) begin
      mem_n[wr_addr] <= wr_data;
    end
    if (state == ST_LOAD) begin
      rd_n_hi <= mem_n[{ws, 1'b0}];
      rd_n_lo <= mem_n[{ws, 1'b1}];
    end
  end

  // ---------------------------------------------------------------------
  // scrambler: the key just written replaces the stored copy
  // ---------------------------------------------------------------------
  assign x_key = (cmd == CMD_WR_X) ? {key_hi, key_lo} : {rd_x_hi, rd_x_lo};

  always_comb begin
    if (cmd == CMD_WR_Y) begin
      y_key = {key_hi, key_lo};
    end else if (cmd == CMD_COMMON) begin
      y_key = common_key_y(cidx);
    end else begin
      y_key = {rd_y_hi, rd_y_lo};
    end
  end

  assign x_rot = {x_key[KEY_W-3:0], x_key[KEY_W-1:KEY_W-2]};
  assign mix   = x_rot ^ y_key;

  // shared 64-bit adder, low word first, carry kept between passes
  assign add_out = {1'b0, add_a} + {1'b0, add_b} + {{WORD_W{1'b0}}, add_cin};

  always_ff @(posedge clk) begin
    if (state == ST_LOW) begin
      sum_lo <= add_out[WORD_W-1:0];
      carry  <= add_out[WORD_W];
    end
    if (state == ST_HIGH) begin
      sum_hi <= add_out[WORD_W-1:0];
    end
  end

  assign sum  = {sum_hi, sum_lo};
  assign norm = {sum[KEY_W-ROT_NORMAL-1:0], sum[KEY_W-1:KEY_W-ROT_NORMAL]};

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  assign rd_key = (cmd == CMD_RD_N) ? {rd_n_hi, rd_n_lo} : {rd_x_hi, rd_x_lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!m_tvalid || m_tready)) begin
      m_tdata[63:0]    <= pres ? rd_key[KEY_W-1:WORD_W] : '0;
      m_tdata[127:64]  <= pres ? rd_key[WORD_W-1:0] : '0;
      m_tdata[128]     <= pres;
      m_tdata[129]     <= fault_q;
      m_tdata[135:130] <= '0;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
`include "aes_key_slot_scrambler_macros.svh"

  // every accepted command starts with the slot lookup
  `AKS_ASSERT_NXT(a_accept_load, s_tvalid && s_tready, state == ST_LOAD)
  // the high adder pass always follows the low pass
  `AKS_ASSERT_IMP(a_high_after_low, state == ST_HIGH, $past(state) == ST_LOW)
  // a rebuilt normal key is only stored for a slot marked valid
  `AKS_ASSERT_IMP(a_norm_valid, state == ST_NLO, valid_normal[ws])

endmodule
